>>> hw/rtl/sfla_pkg.sv
`timescale 1ns / 1ps

package sfla_pkg;

  localparam int unsigned PoolBytes     = 4096;
  localparam int unsigned SlotBytesWide = 22;
  localparam int unsigned ResetLimit    = PoolBytes / SlotBytesWide;

  localparam int unsigned LinkW  = 9;
  localparam int unsigned IndexW = 8;
  localparam int unsigned CountW = 9;

  typedef enum logic [0:0] {
    ActAlloc   = 1'b0,
    ActRelease = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StDone   = 2'd0,
    StFull   = 2'd1,
    StReject = 2'd2
  } status_e;

endpackage

>>> hw/rtl/sfla_if.sv
`timescale 1ns / 1ps

interface sfla_req_if;
  import sfla_pkg::*;

  logic                valid;
  logic                ready;
  action_e             action;
  logic [IndexW-1:0]   slot_index;

  modport source (output valid, output action, output slot_index, input ready);
  modport sink   (input valid, input action, input slot_index, output ready);
endinterface

interface sfla_rsp_if;
  import sfla_pkg::*;

  logic                valid;
  logic                ready;
  status_e             status;
  logic [IndexW-1:0]   granted_slot;
  logic [CountW-1:0]   used_count;

  modport source (output valid, output status, output granted_slot, output used_count,
                  input ready);
  modport sink   (input valid, input status, input granted_slot, input used_count,
                  output ready);
endinterface

interface sfla_cfg_if;
  import sfla_pkg::*;

  logic                valid;
  logic                ready;
  logic [CountW-1:0]   slot_limit;

  modport source (output valid, output slot_limit, input ready);
  modport sink   (input valid, input slot_limit, output ready);
endinterface

>>> hw/rtl/slot_free_list_allocator.sv
`timescale 1ns / 1ps

// Slot allocator with a free list threaded through the free slots. Each request word
// either allocates a slot (pops the list head) or releases a given slot (pushes it on the
// head) and returns exactly one response word with status, granted slot and the used
// count after the request. A release, a failed allocate and a rejected release do not
// hold off the next request; a granting allocate does, because the link of the new head
// is fetched from the link store through its registered read port before another is taken.
// The list restarts in ascending order whenever the used count drops back to zero; this
// needs no rebuild pass, since per-slot written flags are cleared at once and an unwritten
// slot links to the slot above it. The user must write the slot limit register through
// the always ready configuration channel only while the block is idle; it is not enforced.
module slot_free_list_allocator #(
  parameter int unsigned SLOTS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfla_cfg_if.sink   cfg_i,
  sfla_req_if.sink   req_i,
  sfla_rsp_if.source rsp_o
);
  import sfla_pkg::*;

  localparam int unsigned AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CapLim = (SLOTS > 511) ? 511 : SLOTS;

  logic [CountW-1:0] slot_limit_q;
  logic [LinkW-1:0]  head_q, head_d;
  logic [LinkW-1:0]  head_nxt_q, head_nxt_d;
  logic [CountW-1:0] used_q, used_d;
  logic              fresh_q, fresh_d;
  logic              pend_q, pend_d;
  logic [SLOTS-1:0]  written_q;

  logic [LinkW-1:0]  link_mem [SLOTS];
  logic [LinkW-1:0]  rd_data_q;
  logic              rd_hit_q, rd_hit_d;
  logic [LinkW-1:0]  rd_base_q;

  logic              out_vld_q;
  status_e           out_status_q, out_status_d;
  logic [IndexW-1:0] out_grant_q, out_grant_d;
  logic [CountW-1:0] out_used_q;

  logic [CountW-1:0] lim;
  logic              in_ready, fire;
  logic [LinkW-1:0]  eff_head, eff_next;
  logic              alloc_ok, rel_ok, next_in_range;
  logic              rd_en, wr_en, clr_written;
  logic [AW-1:0]     rd_addr, wr_addr;

  assign lim = (slot_limit_q < CountW'(CapLim)) ? slot_limit_q : CountW'(CapLim);

  assign in_ready    = !pend_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = in_ready;
  assign fire        = req_i.valid && in_ready;
  assign cfg_i.ready = 1'b1;

  // a stale list reads as freshly built: head 0, slot 0 linking to slot 1
  assign eff_head = fresh_q ? head_q : '0;
  assign eff_next = fresh_q ? head_nxt_q : LinkW'(1);

  assign alloc_ok = (used_q < lim) && (eff_head < lim);
  assign rel_ok   = ({1'b0, req_i.slot_index} < lim) && (used_q != '0);

  assign next_in_range = 32'(eff_next) < SLOTS;
  assign rd_addr       = AW'(eff_next);
  assign wr_addr       = AW'(req_i.slot_index);

  always_comb begin
    head_d       = head_q;
    head_nxt_d   = head_nxt_q;
    used_d       = used_q;
    fresh_d      = fresh_q;
    pend_d       = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    clr_written  = 1'b0;
    out_status_d = StDone;
    out_grant_d  = '0;
    rd_hit_d     = 1'b0;

    if (pend_q) begin
      head_nxt_d = rd_hit_q ? rd_data_q : rd_base_q + LinkW'(1);
    end

    if (fire) begin
      unique case (req_i.action)
        ActAlloc: begin
          if (!fresh_q) begin
            fresh_d     = 1'b1;
            head_d      = '0;
            head_nxt_d  = LinkW'(1);
            clr_written = 1'b1;
          end
          if (alloc_ok) begin
            head_d      = eff_next;
            used_d      = used_q + CountW'(1);
            out_grant_d = eff_head[IndexW-1:0];
            pend_d      = 1'b1;
            rd_en       = next_in_range;
            rd_hit_d    = next_in_range && !clr_written && written_q[rd_addr];
          end else begin
            out_status_d = StFull;
          end
        end
        ActRelease: begin
          if (rel_ok) begin
            wr_en      = 1'b1;
            head_d     = LinkW'(req_i.slot_index);
            head_nxt_d = head_q;
            used_d     = used_q - CountW'(1);
            if (used_q == CountW'(1)) begin
              fresh_d = 1'b0;
            end
          end else begin
            out_status_d = StReject;
          end
        end
        default: begin
          out_status_d = StReject;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= CountW'(ResetLimit);
      head_q       <= '0;
      head_nxt_q   <= '0;
      used_q       <= '0;
      fresh_q      <= 1'b0;
      pend_q       <= 1'b0;
      written_q    <= '0;
      rd_hit_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        slot_limit_q <= cfg_i.slot_limit;
      end
      head_q     <= head_d;
      head_nxt_q <= head_nxt_d;
      used_q     <= used_d;
      fresh_q    <= fresh_d;
      pend_q     <= pend_d;
      rd_hit_q   <= rd_hit_d;
      if (clr_written) begin
        written_q <= '0;
      end else if (wr_en) begin
        written_q[wr_addr] <= 1'b1;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // link store and its registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr] <= head_q;
    end
    if (rd_en) begin
      rd_data_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_base_q    <= eff_next;
      out_status_q <= out_status_d;
      out_grant_q  <= out_grant_d;
      out_used_q   <= used_d;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.granted_slot = out_grant_q;
  assign rsp_o.used_count   = out_used_q;

endmodule

>>> hw/rtl/sfla_checker.sv
`timescale 1ns / 1ps

module sfla_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input sfla_pkg::status_e         rsp_status_i,
  input logic [sfla_pkg::IndexW-1:0] rsp_granted_slot_i,
  input logic [sfla_pkg::CountW-1:0] rsp_used_count_i
);
  import sfla_pkg::*;

  logic              rsp_fire;
  logic [CountW-1:0] prev_used_q;

  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // used count of the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_used_q <= '0;
    end else if (rsp_fire) begin
      prev_used_q <= rsp_used_count_i;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response word dropped while stalled");

  a_req_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("accepted request word left no response");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire && rsp_status_i != StDone |-> rsp_used_count_i == prev_used_q
      && rsp_granted_slot_i == '0)
    else $error("failed request changed the used count or granted a slot");

  a_done_steps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire && rsp_status_i == StDone |->
      rsp_used_count_i == prev_used_q + CountW'(1)
      || rsp_used_count_i == prev_used_q - CountW'(1))
    else $error("used count moved by other than one");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i == StDone || rsp_status_i == StFull
      || rsp_status_i == StReject)
    else $error("undefined status code");

endmodule

bind slot_free_list_allocator sfla_checker u_sfla_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_granted_slot_i (rsp_o.granted_slot),
  .rsp_used_count_i   (rsp_o.used_count)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sfla_pkg::*;

  localparam int SLOTS      = 256;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    status_e           status;
    logic [IndexW-1:0] granted;
    logic [CountW-1:0] used;
  } slot_reply_t;

  typedef struct {
    bit                is_cfg;
    logic [CountW-1:0] cfg_value;
    action_e           act;
    logic [IndexW-1:0] idx;
    bit                typed;
    slot_reply_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sfla_cfg_if cfg_bus ();
  sfla_req_if req_bus ();
  sfla_rsp_if rsp_bus ();

  slot_free_list_allocator #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always #1 clk = ~clk;

  // allocator shadow state
  logic [LinkW-1:0]  link_mem [SLOTS];
  logic [LinkW-1:0]  free_head;
  logic [CountW-1:0] used_slots;
  bit                list_built;
  logic [CountW-1:0] limit_reg;
  bit                held_map [SLOTS];

  slot_reply_t predicted_replies [$];
  dir_row_t    dir_rows [$];
  int          mismatches;
  int          cycles;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  slot_reply_t seen_want;

  function automatic slot_reply_t allocate_or_release(action_e act, logic [IndexW-1:0] idx);
    slot_reply_t       r;
    logic [CountW-1:0] lim;
    int                i;
    lim = (limit_reg < SLOTS) ? limit_reg : CountW'(SLOTS);
    r.status  = StDone;
    r.granted = '0;
    if (act == ActAlloc) begin
      // a stale list is rebuilt in ascending order before the pop
      if (!list_built) begin
        for (i = 0; i < SLOTS; i++) link_mem[i] = LinkW'(i + 1);
        free_head  = '0;
        list_built = 1'b1;
      end
      if (used_slots >= lim || free_head >= lim) begin
        r.status = StFull;
      end else begin
        r.granted = free_head[IndexW-1:0];
        held_map[free_head[IndexW-1:0]] = 1'b1;
        used_slots = used_slots + 1'b1;
        free_head  = link_mem[free_head[IndexW-1:0]];
      end
    end else if (idx >= lim || used_slots == 0) begin
      r.status = StReject;
    end else begin
      link_mem[idx] = free_head;
      free_head     = {1'b0, idx};
      held_map[idx] = 1'b0;
      used_slots    = used_slots - 1'b1;
      if (used_slots == 0) begin
        list_built = 1'b0;
        for (i = 0; i < SLOTS; i++) held_map[i] = 1'b0;
      end
    end
    r.used = used_slots;
    return r;
  endfunction

  function automatic logic [IndexW-1:0] pick_held(logic [IndexW-1:0] fallback);
    int start;
    int i;
    int j;
    start = $urandom_range(SLOTS - 1);
    for (i = 0; i < SLOTS; i++) begin
      j = (start + i) % SLOTS;
      if (held_map[j]) return IndexW'(j);
    end
    return fallback;
  endfunction

  function automatic void add_req(action_e act, logic [IndexW-1:0] idx);
    dir_row_t row;
    row        = '{is_cfg: 1'b0, cfg_value: '0, act: ActAlloc, idx: '0, typed: 1'b0,
                   want: '0};
    row.act    = act;
    row.idx    = idx;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_chk(action_e act, logic [IndexW-1:0] idx, status_e st,
                                  logic [IndexW-1:0] g, logic [CountW-1:0] u);
    dir_row_t row;
    row        = '{is_cfg: 1'b0, cfg_value: '0, act: ActAlloc, idx: '0, typed: 1'b0,
                   want: '0};
    row.act    = act;
    row.idx    = idx;
    row.typed  = 1'b1;
    row.want   = '{status: st, granted: g, used: u};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CountW-1:0] value);
    dir_row_t row;
    row           = '{is_cfg: 1'b0, cfg_value: '0, act: ActAlloc, idx: '0, typed: 1'b0,
                      want: '0};
    row.is_cfg    = 1'b1;
    row.cfg_value = value;
    dir_rows.push_back(row);
  endfunction

  task automatic send_word(action_e act, logic [IndexW-1:0] idx, bit typed,
                           slot_reply_t want);
    slot_reply_t r;
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    req_bus.valid      <= 1'b1;
    req_bus.action     <= act;
    req_bus.slot_index <= idx;
    do @(posedge clk); while (!req_bus.ready);
    r = allocate_or_release(act, idx);
    if (typed) r = want;
    predicted_replies.push_back(r);
  endtask

  // hold off the sender until every reply is in
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (predicted_replies.size() != 0);
  endtask

  task automatic write_limit(logic [CountW-1:0] value);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.slot_limit <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    limit_reg = value;
  endtask

  task automatic run_phase(logic [CountW-1:0] lim, int n_items);
    int                eff;
    int                burst;
    int                k;
    bit                filling;
    bit                noise;
    action_e           act;
    logic [IndexW-1:0] idx;
    drain();
    write_limit(lim);
    eff     = (lim < SLOTS) ? int'(lim) : SLOTS;
    // open with a run of allocates long enough to fill the pool
    filling = 1'b1;
    burst   = eff + 2;
    for (k = 0; k < n_items; k++) begin
      if (k == n_items / 2) drain();
      if (burst == 0) begin
        filling = !filling;
        burst   = $urandom_range(eff + 2, 1);
      end
      burst--;
      idx   = IndexW'($urandom_range(255));
      noise = ($urandom_range(9) == 0);
      if (noise) begin
        act = action_e'($urandom_range(1));
      end else if (filling) begin
        act = ($urandom_range(9) == 0) ? ActRelease : ActAlloc;
      end else begin
        act = ($urandom_range(9) == 0) ? ActAlloc : ActRelease;
      end
      if (act == ActRelease && !noise) idx = pick_held(idx);
      send_word(act, idx, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (predicted_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected reply status=%0d granted=%0d used=%0d", $realtime,
                   rsp_bus.status, rsp_bus.granted_slot, rsp_bus.used_count);
      end else begin
        seen_want = predicted_replies.pop_front();
        if (rsp_bus.status !== seen_want.status || rsp_bus.granted_slot !== seen_want.granted ||
            rsp_bus.used_count !== seen_want.used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reply mismatch exp %0d/%0d/%0d got %0d/%0d/%0d (status/slot/used)",
                     $realtime, seen_want.status, seen_want.granted, seen_want.used,
                     rsp_bus.status, rsp_bus.granted_slot, rsp_bus.used_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int k;
    rst_n              = 1'b0;
    cycles             = 0;
    mismatches         = 0;
    req_bus.valid      = 1'b0;
    req_bus.action     = ActAlloc;
    req_bus.slot_index = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.slot_limit = '0;
    rsp_bus.ready      = 1'b0;
    free_head          = '0;
    used_slots         = '0;
    list_built         = 1'b0;
    limit_reg          = CountW'(ResetLimit);
    for (k = 0; k < SLOTS; k++) held_map[k] = 1'b0;
    snd_idle_pct = 16;
    rcv_idle_pct = 63;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit, release on empty pool, release at and past the limit
    add_chk(ActRelease, 8'd0,   StReject, 8'd0, 9'd0);
    add_chk(ActAlloc,   8'd77,  StDone,   8'd0, 9'd1);
    add_chk(ActAlloc,   8'd255, StDone,   8'd1, 9'd2);
    add_chk(ActRelease, 8'd185, StDone,   8'd0, 9'd1);
    add_chk(ActRelease, 8'd186, StReject, 8'd0, 9'd1);
    add_chk(ActRelease, 8'd255, StReject, 8'd0, 9'd1);
    add_req(ActAlloc,   8'd0);
    add_req(ActAlloc,   8'd0);
    // drain to empty so the next allocate restarts from slot zero
    add_req(ActRelease, 8'd2);
    add_req(ActRelease, 8'd1);
    add_req(ActRelease, 8'd0);
    add_chk(ActAlloc,   8'd0,   StDone,   8'd0, 9'd1);
    add_cfg(9'd1);
    add_chk(ActAlloc,   8'd0,   StFull,   8'd0, 9'd1);
    add_chk(ActRelease, 8'd0,   StDone,   8'd0, 9'd0);
    add_chk(ActAlloc,   8'd0,   StDone,   8'd0, 9'd1);
    add_chk(ActRelease, 8'd1,   StReject, 8'd0, 9'd1);
    add_cfg(9'd0);
    add_chk(ActAlloc,   8'd0,   StFull,   8'd0, 9'd1);
    add_chk(ActRelease, 8'd0,   StReject, 8'd0, 9'd1);
    add_cfg(9'd256);
    add_req(ActAlloc,   8'd0);
    add_req(ActAlloc,   8'd0);
    // double release of a high slot, then shrink the limit under the head
    add_req(ActRelease, 8'd200);
    add_req(ActRelease, 8'd200);
    add_cfg(9'd4);
    add_req(ActAlloc,   8'd0);
    add_req(ActRelease, 8'd255);
    add_req(ActRelease, 8'd3);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        drain();
        write_limit(dir_rows[k].cfg_value);
      end else begin
        send_word(dir_rows[k].act, dir_rows[k].idx, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    run_phase(CountW'(ResetLimit), 90);
    run_phase(9'd1, 40);
    run_phase(CountW'($urandom_range(256, 1)), 80);

    snd_idle_pct = 63;
    rcv_idle_pct = 16;
    run_phase(9'd256, 300);
    run_phase(9'd0, 20);
    run_phase(CountW'($urandom_range(256, 1)), 80);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(9'd2, 40);
    run_phase(CountW'($urandom_range(256, 1)), 80);
    run_phase(9'd255, 80);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
